/* hw/rtl/box_range_count_engine_assert.svh */
// Assertion macros for the box range count engine.
`ifndef BOX_RANGE_COUNT_ENGINE_ASSERT_SVH
`define BOX_RANGE_COUNT_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS
// label: name of the check, prop: property body sampled on clk, held off in reset
`define BRC_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// expr must never hold outside reset
`define BRC_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define BRC_ASSERT(label, clk, rst_n, prop, msg)
`define BRC_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

/* hw/rtl/brc_pkg.sv */
`default_nettype none
package brc_pkg;

	localparam int DEF_MAX_DIMS    = 8;
	localparam int DEF_MAX_QUERIES = 64;
	localparam int DEF_COUNT_BITS  = 32;

	// wide enough for any cell index and any query count compare
	localparam int IDX_W = 13;

	typedef enum logic [2:0] {
		OP_LOAD_SCALE  = 3'd0,
		OP_LOAD_BOUNDS = 3'd1,
		OP_POINT       = 3'd2,
		OP_READ        = 3'd3,
		OP_CLEAR       = 3'd4
	} op_t;

	typedef enum logic [0:0] {
		REG_DIMS    = 1'b0,
		REG_QUERIES = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [2:0]         operation;
		logic [5:0]         query_index;
		logic [2:0]         dim_index;
		logic signed [31:0] coordinate;
		logic signed [31:0] dim_offset;
		logic [31:0]        dim_gain;
		logic signed [31:0] dim_base;
		logic signed [31:0] bound_low;
		logic signed [31:0] bound_high;
	} cmd_t;

	typedef struct packed {
		logic [5:0]  count_query;
		logic [31:0] point_count;
	} result_t;

	// word handed from cell to cell
	typedef struct packed {
		logic               valid;
		op_t                op;
		logic [5:0]         query;
		logic [2:0]         dim;
		logic               first;
		logic               last;
		logic [6:0]         nq;
		logic signed [31:0] lo;   // quantized value for points, low bound for loads
		logic signed [31:0] hi;
		logic [31:0]        cnt;
	} lane_t;

endpackage
`default_nettype wire

/* hw/rtl/brc_quant.sv */
`default_nettype none
module brc_quant import brc_pkg::*; #(
	parameter int MAX_DIMS = DEF_MAX_DIMS
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       take,
	input  wire cmd_t       cmd,
	input  wire logic [3:0] dims_in_use,
	input  wire logic [6:0] queries_in_use,
	output lane_t           lane_o
);

	localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

	logic signed [31:0] offset_q [MAX_DIMS];
	logic [31:0]        gain_q   [MAX_DIMS];
	logic signed [31:0] base_q   [MAX_DIMS];

	logic [DW-1:0] dsel;
	logic          dim_ok;
	logic [4:0]    dims_eff;
	logic          dim_used;
	lane_t         lane_in;

	lane_t lane_s1, lane_s2, lane_s3, lane_s4, lane_s5;
	logic signed [32:0] diff_s1;
	logic [31:0]        gain_s1, gain_s2, gain_s3;
	logic signed [31:0] base_s1, base_s2, base_s3, base_s4;
	logic [32:0]        mag_s2;
	logic               neg_s2, neg_s3, neg_s4;
	logic [63:0]        plo_s3;
	logic               m32_s3;
	logic [31:0]        hi_s4;
	logic               frac_s4;

	logic signed [33:0] sum;
	logic signed [31:0] qval;
	lane_t              lane_fix;

	always_comb begin
		dsel     = DW'(cmd.dim_index);
		dim_ok   = {2'b00, cmd.dim_index} < 5'(MAX_DIMS);
		dims_eff = ({1'b0, dims_in_use} > 5'(MAX_DIMS)) ? 5'(MAX_DIMS) : {1'b0, dims_in_use};
		dim_used = {2'b00, cmd.dim_index} < dims_eff;

		lane_in       = '0;
		lane_in.op    = op_t'(cmd.operation);
		lane_in.query = cmd.query_index;
		lane_in.dim   = cmd.dim_index;
		lane_in.first = cmd.dim_index == 3'd0;
		lane_in.last  = {2'b00, cmd.dim_index} == dims_eff - 5'd1;
		lane_in.nq    = queries_in_use;
		lane_in.lo    = cmd.bound_low;
		lane_in.hi    = cmd.bound_high;
		lane_in.valid = take && ((cmd.operation == OP_LOAD_BOUNDS) ||
			(cmd.operation == OP_READ) || (cmd.operation == OP_CLEAR) ||
			((cmd.operation == OP_POINT) && dim_used));
	end

	always_ff @(posedge clk) begin
		if (take && (cmd.operation == OP_LOAD_SCALE) && dim_ok) begin
			offset_q[dsel] <= cmd.dim_offset;
			gain_q[dsel]   <= cmd.dim_gain;
			base_q[dsel]   <= cmd.dim_base;
		end
	end

	// math path: difference, magnitude, multiply, high word, rebase and clamp
	always_ff @(posedge clk) begin
		diff_s1 <= 33'(cmd.coordinate) - 33'(offset_q[dsel]);
		gain_s1 <= gain_q[dsel];
		base_s1 <= base_q[dsel];

		neg_s2  <= diff_s1[32];
		mag_s2  <= diff_s1[32] ? 33'(-diff_s1) : 33'(diff_s1);
		gain_s2 <= gain_s1;
		base_s2 <= base_s1;

		plo_s3  <= mag_s2[31:0] * gain_s2;
		m32_s3  <= mag_s2[32];
		neg_s3  <= neg_s2;
		gain_s3 <= gain_s2;
		base_s3 <= base_s2;

		// magnitude is at most 2^32 so the product fits 64 bits
		hi_s4   <= plo_s3[63:32] + (m32_s3 ? gain_s3 : 32'd0);
		frac_s4 <= |plo_s3[31:0];
		neg_s4  <= neg_s3;
		base_s4 <= base_s3;
	end

	always_comb begin
		// negative side rounds toward minus infinity
		if (neg_s4) begin
			sum = 34'(base_s4) - $signed({2'b00, hi_s4}) - $signed({33'd0, frac_s4});
		end else begin
			sum = 34'(base_s4) + $signed({2'b00, hi_s4});
		end
		if (sum > 34'sh0_7FFF_FFFF) begin
			qval = 32'sh7FFF_FFFF;
		end else if (sum < -34'sh0_8000_0000) begin
			qval = -32'sh8000_0000;
		end else begin
			qval = sum[31:0];
		end
		lane_fix = lane_s4;
		if (lane_s4.op == OP_POINT) begin
			lane_fix.lo = qval;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_s1 <= '0;
			lane_s2 <= '0;
			lane_s3 <= '0;
			lane_s4 <= '0;
			lane_s5 <= '0;
		end else begin
			lane_s1 <= lane_in;
			lane_s2 <= lane_s1;
			lane_s3 <= lane_s2;
			lane_s4 <= lane_s3;
			lane_s5 <= lane_fix;
		end
	end

	assign lane_o = lane_s5;

endmodule
`default_nettype wire

/* hw/rtl/brc_cell.sv */
`default_nettype none
module brc_cell import brc_pkg::*; #(
	parameter int MAX_DIMS   = DEF_MAX_DIMS,
	parameter int COUNT_BITS = DEF_COUNT_BITS,
	parameter int IDX        = 0
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire lane_t lane_i,
	output lane_t      lane_o
);

	localparam int                    DW      = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam logic [IDX_W-1:0]      MY_IDX  = IDX_W'(IDX);
	localparam logic [COUNT_BITS-1:0] CNT_CAP = COUNT_BITS'(32'hFFFF_FFFF);

	logic signed [31:0] low_q  [MAX_DIMS];
	logic signed [31:0] high_q [MAX_DIMS];
	logic               inside_q;
	logic [COUNT_BITS-1:0] count_q;
	lane_t              lane_q;

	logic [DW-1:0] dsel;
	logic          mine, active, dim_ok, miss, flag_base, flag_new;
	logic [31:0]   rd;
	lane_t         lane_nxt;

	always_comb begin
		dsel      = DW'(lane_i.dim);
		mine      = IDX_W'(lane_i.query) == MY_IDX;
		active    = IDX_W'(lane_i.nq) > MY_IDX;
		dim_ok    = {2'b00, lane_i.dim} < 5'(MAX_DIMS);
		miss      = (lane_i.lo < low_q[dsel]) || (lane_i.lo > high_q[dsel]);
		flag_base = lane_i.first ? active : inside_q;
		flag_new  = flag_base && !(active && miss);
		rd        = (count_q > CNT_CAP) ? 32'hFFFF_FFFF : 32'(count_q);
		lane_nxt  = lane_i;
		if ((lane_i.op == OP_READ) && mine) begin
			lane_nxt.cnt = rd;
		end
	end

	always_ff @(posedge clk) begin
		if (lane_i.valid && (lane_i.op == OP_LOAD_BOUNDS) && mine && dim_ok) begin
			low_q[dsel]  <= lane_i.lo;
			high_q[dsel] <= lane_i.hi;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
			count_q  <= '0;
		end else if (lane_i.valid) begin
			unique case (lane_i.op)
				OP_CLEAR: begin
					inside_q <= 1'b0;
					count_q  <= '0;
				end
				OP_POINT: begin
					inside_q <= flag_new;
					if (lane_i.last && active && flag_new && !(&count_q)) begin
						count_q <= count_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_q <= '0;
		end else begin
			lane_q <= lane_nxt;
		end
	end

	assign lane_o = lane_q;

endmodule
`default_nettype wire

/* hw/rtl/box_range_count_engine.sv */
// Path: a read count word passes the five quantizer stages, then one register per
// query cell along the chain, before its result shows on done.
// Throughput: one word per cycle; busy stays low, the chain takes a word every cycle.
// Results show on done for one cycle each; the receiver cannot stall them.
// Reset (arst_n low): counts and inside flags cleared, dims_in_use = 1,
// queries_in_use = 64; scaling entries and bounds are undefined until loaded.
`default_nettype none
`include "box_range_count_engine_assert.svh"
module box_range_count_engine import brc_pkg::*; #(
	parameter int MAX_DIMS    = DEF_MAX_DIMS,
	parameter int MAX_QUERIES = DEF_MAX_QUERIES,
	parameter int COUNT_BITS  = DEF_COUNT_BITS
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire cmd_t       cmd,
	input  wire logic       cfg_we,
	input  wire logic [0:0] cfg_index,
	input  wire logic [6:0] cfg_wdata,
	output logic            done,
	output result_t         result
);

	localparam int LATENCY = MAX_QUERIES + 5;

	logic [3:0] dims_q;
	logic [6:0] nq_q;
	logic       take;
	lane_t      chain [MAX_QUERIES+1];

	assign busy = 1'b0;
	assign take = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q <= 4'd1;
			nq_q   <= 7'd64;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DIMS:    dims_q <= cfg_wdata[3:0];
				REG_QUERIES: nq_q   <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	brc_quant #(
		.MAX_DIMS(MAX_DIMS)
	) u_quant (
		.clk            (clk),
		.arst_n         (arst_n),
		.take           (take),
		.cmd            (cmd),
		.dims_in_use    (dims_q),
		.queries_in_use (nq_q),
		.lane_o         (chain[0])
	);

	for (genvar g = 0; g < MAX_QUERIES; g++) begin : g_cell
		brc_cell #(
			.MAX_DIMS   (MAX_DIMS),
			.COUNT_BITS (COUNT_BITS),
			.IDX        (g)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.lane_i (chain[g]),
			.lane_o (chain[g+1])
		);
	end

	assign done   = chain[MAX_QUERIES].valid && (chain[MAX_QUERIES].op == OP_READ);
	assign result = {chain[MAX_QUERIES].query, chain[MAX_QUERIES].cnt};

	`BRC_ASSERT(a_read_gives_result, clk, arst_n, take && (cmd.operation == OP_READ) |-> ##LATENCY done, "accepted read gave no result")
	`BRC_ASSERT(a_result_from_read, clk, arst_n, done |-> $past(take && (cmd.operation == OP_READ), LATENCY), "result without a read")
	`BRC_NEVER(a_read_echo, clk, arst_n, done && (result.count_query != $past(cmd.query_index, LATENCY)), "result names the wrong query")

endmodule
`default_nettype wire

/* verif/brc_count_check.sv */
module brc_count_check import brc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic       busy,
	input  wire cmd_t       cmd,
	input  wire logic       cfg_we,
	input  wire logic [0:0] cfg_index,
	input  wire logic [6:0] cfg_wdata,
	input  wire logic       done,
	input  wire result_t    result,
	output int              fails,
	output int              pending
);

	localparam int NDIM = DEF_MAX_DIMS;
	localparam int NQ   = DEF_MAX_QUERIES;
	localparam longint Q_MAX = 64'sh7FFFFFFF;
	localparam longint Q_MIN = -64'sh80000000;

	logic [3:0]         dims_reg;
	logic [6:0]         queries_reg;
	logic signed [31:0] off_tab [NDIM];
	logic [31:0]        gain_tab [NDIM];
	logic signed [31:0] base_tab [NDIM];
	logic signed [31:0] low_tab [NQ][NDIM];
	logic signed [31:0] high_tab [NQ][NDIM];
	bit                 in_box [NQ];
	logic [31:0]        hits [NQ];
	result_t            counts_due [$];
	result_t            want;

	// base + floor(gain * (c - offset)), gain unsigned Q0.32, clamped to 32 bits
	function automatic logic signed [31:0] quantize_coord(int d, logic signed [31:0] c);
		longint diff, whole, q;
		longint unsigned mag, prod;
		diff = longint'(c) - longint'(off_tab[d]);
		mag = (diff < 0) ? -diff : diff;
		prod = mag * {32'd0, gain_tab[d]};
		if (diff < 0)
			whole = -longint'((prod >> 32) + (prod[31:0] != 0));
		else
			whole = longint'(prod >> 32);
		q = longint'(base_tab[d]) + whole;
		if (q > Q_MAX)
			q = Q_MAX;
		else if (q < Q_MIN)
			q = Q_MIN;
		return q[31:0];
	endfunction

	task automatic track_command(cmd_t w);
		int eff_dims, eff_q;
		logic signed [31:0] v;
		result_t r;
		eff_dims = (dims_reg > NDIM) ? NDIM : dims_reg;
		eff_q = (queries_reg > NQ) ? NQ : queries_reg;
		case (w.operation)
			OP_LOAD_SCALE: begin
				off_tab[w.dim_index] = w.dim_offset;
				gain_tab[w.dim_index] = w.dim_gain;
				base_tab[w.dim_index] = w.dim_base;
			end
			OP_LOAD_BOUNDS: begin
				low_tab[w.query_index][w.dim_index] = w.bound_low;
				high_tab[w.query_index][w.dim_index] = w.bound_high;
			end
			OP_POINT: begin
				if (w.dim_index < eff_dims) begin
					v = quantize_coord(w.dim_index, w.coordinate);
					// dimension 0 opens a new point
					if (w.dim_index == 0)
						for (int q = 0; q < NQ; q++)
							in_box[q] = (q < eff_q);
					for (int q = 0; q < eff_q; q++)
						if (v < low_tab[q][w.dim_index] || v > high_tab[q][w.dim_index])
							in_box[q] = 0;
					if (w.dim_index == eff_dims - 1)
						for (int q = 0; q < eff_q; q++)
							if (in_box[q] && hits[q] != '1)
								hits[q]++;
				end
			end
			OP_READ: begin
				r.count_query = w.query_index;
				r.point_count = hits[w.query_index];
				counts_due = {counts_due, r};
			end
			OP_CLEAR: begin
				in_box = '{default: 0};
				hits = '{default: '0};
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_reg = 4'd1;
			queries_reg = 7'd64;
			in_box = '{default: 0};
			hits = '{default: '0};
			counts_due.delete();
			fails = 0;
			pending = 0;
		end else begin
			if (done) begin
				if (counts_due.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("unexpected count word: query %0d count %0d",
							result.count_query, result.point_count);
				end else begin
					want = counts_due.pop_front();
					if (result.count_query !== want.count_query ||
							result.point_count !== want.point_count) begin
						fails++;
						if (fails <= 10)
							$display("count mismatch: query exp %0d got %0d, count exp %0d got %0d",
								want.count_query, result.count_query,
								want.point_count, result.point_count);
					end
				end
			end
			if (cfg_we) begin
				if (cfg_index == REG_DIMS)
					dims_reg = cfg_wdata[3:0];
				else
					queries_reg = cfg_wdata;
			end
			if (start && !busy)
				track_command(cmd);
			pending = counts_due.size();
		end
	end

endmodule

/* verif/tb.sv */
module tb;
	import brc_pkg::*;

	localparam int SETTLE       = DEF_MAX_QUERIES + 5 + 16;
	localparam int LIMIT        = 200000;
	localparam int RANDOM_WORDS = 700;
	localparam int PHASE_WORDS  = 120;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	cmd_t       cmd = '0;
	logic       cfg_we = 1'b0;
	logic [0:0] cfg_index = REG_DIMS;
	logic [6:0] cfg_wdata = '0;
	logic       busy;
	logic       done;
	result_t    result;
	int         fails;
	int         pending;

	int cycles = 0;
	int burst_left = 0;
	int dims_now = 1;
	int random_words = 0;
	int plan_dims [12] = '{1, 8, 0, 15, 3, 2, 5, 9, 4, 8, 1, 6};
	int plan_nq [12] = '{64, 64, 10, 127, 0, 1, 33, 65, 64, 7, 127, 20};

	box_range_count_engine DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.done(done),
		.result(result)
	);

	brc_count_check count_check (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.done(done),
		.result(result),
		.fails(fails),
		.pending(pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic cmd_t any_word(op_t op, int qi, int di);
		cmd_t w;
		w.coordinate = $urandom;
		w.dim_offset = $urandom;
		w.dim_gain = $urandom;
		w.dim_base = $urandom;
		w.bound_low = $urandom;
		w.bound_high = $urandom;
		w.operation = op;
		w.query_index = 6'(qi);
		w.dim_index = 3'(di);
		return w;
	endfunction

	function automatic logic signed [31:0] near_coord();
		return (int'($urandom_range(0, 120)) - 60) * 65536 + int'($urandom_range(0, 65535));
	endfunction

	function automatic cmd_t scale_word(int di, bit tame);
		cmd_t w;
		w = any_word(OP_LOAD_SCALE, $urandom_range(0, 63), di);
		if (tame) begin
			w.dim_offset = (int'($urandom_range(0, 8)) - 4) * 65536 + int'($urandom_range(0, 65535));
			w.dim_gain = $urandom_range(32'h8000, 32'h18000);
			w.dim_base = int'($urandom_range(0, 10)) - 5;
		end
		return w;
	endfunction

	function automatic cmd_t bounds_word(int qi, int di, bit tame);
		cmd_t w;
		int lo;
		w = any_word(OP_LOAD_BOUNDS, qi, di);
		if (tame) begin
			lo = int'($urandom_range(0, 100)) - 80;
			w.bound_low = lo;
			w.bound_high = lo + int'($urandom_range(0, 120));
		end
		return w;
	endfunction

	function automatic cmd_t scale_set(int di, logic [31:0] off, logic [31:0] gain,
			logic [31:0] base);
		cmd_t w;
		w = any_word(OP_LOAD_SCALE, $urandom_range(0, 63), di);
		w.dim_offset = off;
		w.dim_gain = gain;
		w.dim_base = base;
		return w;
	endfunction

	function automatic cmd_t bounds_set(int qi, int di, logic [31:0] lo, logic [31:0] hi);
		cmd_t w;
		w = any_word(OP_LOAD_BOUNDS, qi, di);
		w.bound_low = lo;
		w.bound_high = hi;
		return w;
	endfunction

	function automatic cmd_t coord_at(int di, logic [31:0] c);
		cmd_t w;
		w = any_word(OP_POINT, $urandom_range(0, 63), di);
		w.coordinate = c;
		return w;
	endfunction

	function automatic cmd_t coord_word(int di);
		cmd_t w;
		w = any_word(OP_POINT, $urandom_range(0, 63), di);
		if ($urandom_range(0, 19) != 0)
			w.coordinate = near_coord();
		return w;
	endfunction

	function automatic cmd_t read_word(int qi);
		return any_word(OP_READ, qi, $urandom_range(0, 7));
	endfunction

	// sender works in bursts; start stays high across back-to-back words
	task automatic push_word(cmd_t w);
		if (burst_left == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 16);
		end
		burst_left--;
		start <= 1'b1;
		cmd <= w;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// all reads answered, then let any points still in the chain finish
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic configure(int d, int n);
		cfg_we <= 1'b1;
		cfg_index <= REG_DIMS;
		cfg_wdata <= {3'($urandom_range(0, 7)), 4'(d)};
		@(posedge clk);
		cfg_index <= REG_QUERIES;
		cfg_wdata <= 7'(n);
		@(posedge clk);
		cfg_we <= 1'b0;
		dims_now = d;
	endtask

	function automatic int live_dims();
		return (dims_now > DEF_MAX_DIMS) ? DEF_MAX_DIMS : dims_now;
	endfunction

	// one point, dimension 0 upward; now and then cut short
	task automatic point_run();
		int eff, d;
		eff = live_dims();
		if (eff == 0) begin
			push_word(coord_word($urandom_range(0, 7)));
		end else begin
			for (d = 0; d < eff; d++) begin
				if (d > 0 && $urandom_range(0, 29) == 0)
					break;
				push_word(coord_word(d));
				random_words++;
			end
		end
	endtask

	task automatic mixed_step();
		int pick, di;
		pick = $urandom_range(0, 99);
		if (pick < 58) begin
			point_run();
		end else if (pick < 74 || pick >= 96) begin
			push_word(read_word($urandom_range(0, 63)));
			random_words++;
		end else if (pick < 80) begin
			di = $urandom_range(0, 7);
			push_word(coord_word(di));
			if (di < live_dims())
				random_words++;
		end else if (pick < 87) begin
			push_word(bounds_word($urandom_range(0, 63), $urandom_range(0, 7),
				$urandom_range(0, 9) != 0));
			random_words++;
		end else if (pick < 92) begin
			push_word(scale_word($urandom_range(0, 7), $urandom_range(0, 7) != 0));
			random_words++;
		end else if (pick < 94) begin
			push_word(any_word(OP_CLEAR, $urandom_range(0, 63), $urandom_range(0, 7)));
			random_words++;
		end else begin
			push_word(any_word(op_t'($urandom_range(5, 7)), $urandom_range(0, 63),
				$urandom_range(0, 7)));
		end
	endtask

	initial begin
		int phase, target;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// every scaling entry and bound is loaded before the first point
		for (int d = 0; d < DEF_MAX_DIMS; d++)
			push_word(scale_word(d, 1'b1));
		for (int q = 0; q < DEF_MAX_QUERIES; q++)
			for (int d = 0; d < DEF_MAX_DIMS; d++)
				push_word(bounds_word(q, d, 1'b1));

		// directed: saturation both ways, floor toward minus infinity, zero gain
		push_word(scale_set(0, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF));
		push_word(bounds_set(0, 0, 32'h8000_0000, 32'h7FFF_FFFF));
		push_word(bounds_set(63, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		push_word(bounds_set(1, 0, 32'h8000_0000, 32'h8000_0000));
		push_word(coord_at(0, 32'h7FFF_FFFF));
		push_word(scale_set(0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000));
		push_word(coord_at(0, 32'h8000_0000));
		push_word(scale_set(0, 32'h0000_0000, 32'h0000_8000, 32'h0000_0000));
		push_word(bounds_set(2, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		push_word(coord_at(0, 32'hFFFF_0000));
		push_word(coord_at(0, 32'hFFFF_FFFF));
		push_word(coord_at(0, 32'h0000_0001));
		push_word(scale_set(0, 32'h1234_5678, 32'h0000_0000, 32'hFFFF_FFFF));
		push_word(coord_at(0, $urandom));
		push_word(bounds_set(63, 7, 32'h8000_0000, 32'h7FFF_FFFF));
		push_word(coord_at(7, $urandom));
		push_word(read_word(0));
		push_word(read_word(1));
		push_word(read_word(2));
		push_word(read_word(63));
		push_word(any_word(op_t'(3'd5), 0, 0));
		push_word(any_word(op_t'(3'd6), 63, 7));
		push_word(any_word(op_t'(3'd7), $urandom_range(0, 63), $urandom_range(0, 7)));
		push_word(any_word(OP_CLEAR, 0, 0));
		push_word(read_word(0));
		push_word(read_word(63));
		push_word(scale_word(0, 1'b1));
		push_word(bounds_word(0, 0, 1'b1));
		push_word(bounds_word(1, 0, 1'b1));
		push_word(bounds_word(2, 0, 1'b1));
		push_word(bounds_word(63, 0, 1'b1));
		push_word(bounds_word(63, 7, 1'b1));

		phase = 0;
		while (random_words < RANDOM_WORDS) begin
			drain();
			if (phase < 12)
				configure(plan_dims[phase], plan_nq[phase]);
			else
				configure($urandom_range(0, 15), $urandom_range(0, 127));
			phase++;
			target = random_words + PHASE_WORDS;
			while (random_words < target)
				mixed_step();
			repeat (4) begin
				push_word(read_word($urandom_range(0, 63)));
				random_words++;
			end
		end

		drain();
		if (fails == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
